/* hw/rtl/psv_pkg.sv */
// ----------------------------------------------------------------------------
// psv_pkg
// shared widths, defaults and register indexes of the scattering vector block
// ----------------------------------------------------------------------------
package psv_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int OUT_BITS_DEF   = 24;

	// square root chain: 62-bit radicand, 31-bit root
	localparam int SQ_N_W    = 62;
	localparam int SQ_ROOT_W = 31;
	localparam int SQ_REM_W  = 33;

	typedef enum logic [2:0] {
		REG_PIXEL_SIZE = 3'd0,
		REG_FAST_AXIS  = 3'd1,
		REG_SLOW_AXIS  = 3'd2,
		REG_ORIGIN     = 3'd3,
		REG_BEAM_DIR   = 3'd4,
		REG_WAVE_LEN   = 3'd5
	} reg_idx_t;

	function automatic logic signed [15:0] comp16(input logic [47:0] v, input int unsigned i);
		comp16 = $signed(v[16*i +: 16]);
	endfunction

endpackage

/* hw/rtl/psv_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// psv_sqrt_cell
// one registered digit step of the integer square root
// ----------------------------------------------------------------------------
module psv_sqrt_cell import psv_pkg::*; (
	input  logic                 clk,
	input  logic [SQ_REM_W-1:0]  rem_i,
	input  logic [SQ_ROOT_W-1:0] root_i,
	input  logic [SQ_N_W-1:0]    n_i,
	output logic [SQ_REM_W-1:0]  rem_o,
	output logic [SQ_ROOT_W-1:0] root_o,
	output logic [SQ_N_W-1:0]    n_o
);

	logic [SQ_REM_W+1:0] t;
	logic [SQ_REM_W+1:0] trial;
	logic                ge;

	always_comb begin
		t     = {rem_i, n_i[SQ_N_W-1 -: 2]};
		trial = (SQ_REM_W+2)'({root_i, 2'b01});
		ge    = (t >= trial);
	end

	always_ff @(posedge clk) begin
		rem_o  <= ge ? SQ_REM_W'(t - trial) : SQ_REM_W'(t);
		root_o <= {root_i[SQ_ROOT_W-2:0], ge};
		n_o    <= {n_i[SQ_N_W-3:0], 2'b00};
	end

endmodule

/* hw/rtl/psv_div_cell.sv */
// ----------------------------------------------------------------------------
// psv_div_cell
// one registered quotient bit of a restoring divider
// ----------------------------------------------------------------------------
module psv_div_cell #(
	parameter int DW = 32,
	parameter int QW = 31
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] low_i,
	input  logic [DW-1:0] div_i,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] low_o,
	output logic [DW-1:0] div_o
);

	logic [DW:0] t;
	logic        ge;

	always_comb begin
		t  = {rem_i, low_i[QW-1]};
		ge = (t >= {1'b0, div_i});
	end

	always_ff @(posedge clk) begin
		rem_o <= ge ? DW'(t - {1'b0, div_i}) : DW'(t);
		low_o <= {low_i[QW-2:0], ge};
		div_o <= div_i;
	end

endmodule

/* hw/rtl/pixel_scattering_vector.sv */
// ----------------------------------------------------------------------------
// pixel_scattering_vector
// scattering vector of one detector pixel from the configured geometry
// ----------------------------------------------------------------------------
// Takes one pixel per clock (busy never rises) and returns its result on the
// done strobe after passing through the cell chains: 8 front stages for
// position, normalization and length squared, 31 square root cells, 31 cells
// for the unit direction, 2 stages for the beam difference, 35 cells for the
// wavelength division and one output register.
// The receiver cannot stall; results must be taken on the done cycle.
// Configuration writes are always ready and must only happen while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module pixel_scattering_vector import psv_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int OUT_BITS   = OUT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [COORD_BITS-1:0]      pixel_row,
	input  logic [COORD_BITS-1:0]      pixel_col,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [2:0]                 cfg_index,
	input  logic [47:0]                cfg_data,
	output logic                       done,
	output logic signed [OUT_BITS-1:0] s_x,
	output logic signed [OUT_BITS-1:0] s_y,
	output logic signed [OUT_BITS-1:0] s_z,
	output logic                       zero_distance
);

	localparam int PROD_W = COORD_BITS + 16;
	localparam int MUL_W  = COORD_BITS + 33;
	localparam int PW     = COORD_BITS + 35;
	localparam int MW     = PW - 1;
	localparam int HW     = $clog2(MW);
	localparam int D1_DW  = 32;
	localparam int D1_QW  = 31;
	localparam int D2_DW  = 17;
	localparam int D2_QW  = 35;
	localparam int N2_W   = D2_QW + 1;
	localparam logic [D2_QW-1:0] PMAX = D2_QW'((64'd1 << (OUT_BITS-1)) - 64'd1);
	localparam logic [D2_QW-1:0] NMAX = D2_QW'(64'd1 << (OUT_BITS-1));

	typedef struct packed {
		logic             zero;
		logic [2:0]       neg;
		logic [2:0][29:0] nm;
	} sq_tag_t;

	typedef struct packed {
		logic       zero;
		logic [2:0] neg;
	} d_tag_t;

	// configuration
	logic [15:0] pixel_size_q;
	logic [47:0] fast_axis_q;
	logic [47:0] slow_axis_q;
	logic [47:0] origin_q;
	logic [47:0] beam_dir_q;
	logic [15:0] wave_len_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_size_q <= '0;
			fast_axis_q  <= '0;
			slow_axis_q  <= '0;
			origin_q     <= '0;
			beam_dir_q   <= '0;
			wave_len_q   <= 16'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PIXEL_SIZE: pixel_size_q <= cfg_data[15:0];
				REG_FAST_AXIS:  fast_axis_q  <= cfg_data;
				REG_SLOW_AXIS:  slow_axis_q  <= cfg_data;
				REG_ORIGIN:     origin_q     <= cfg_data;
				REG_BEAM_DIR:   beam_dir_q   <= cfg_data;
				REG_WAVE_LEN:   wave_len_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// front valid line
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	logic [PROD_W-1:0]       colps_s1, rowps_s1;
	logic signed [MUL_W-1:0] f_s2 [3];
	logic signed [MUL_W-1:0] s_s2 [3];
	logic signed [PW-1:0]    p_s3 [3];
	logic [MW-1:0]           mag_s4 [3];
	logic [2:0]              neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic [MW-1:0]           mag_s5 [3];
	logic [HW-1:0]           h_s5;
	logic                    zero_s5, zero_s6, zero_s7, zero_s8;
	logic [2:0][29:0]        nm_s6, nm_s7, nm_s8;
	logic [59:0]             sq_s7 [3];
	logic [SQ_N_W-1:0]       l2_s8;

	logic [MW-1:0] orv;
	logic [HW-1:0] h_c;

	always_comb begin
		orv = mag_s4[0] | mag_s4[1] | mag_s4[2];
		h_c = '0;
		for (int j = 0; j < MW; j++) begin
			if (orv[j]) begin
				h_c = HW'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		colps_s1 <= PROD_W'(pixel_col) * PROD_W'(pixel_size_q);
		rowps_s1 <= PROD_W'(pixel_row) * PROD_W'(pixel_size_q);
		for (int i = 0; i < 3; i++) begin
			f_s2[i]   <= $signed({1'b0, colps_s1}) * comp16(fast_axis_q, i);
			s_s2[i]   <= $signed({1'b0, rowps_s1}) * comp16(slow_axis_q, i);
			p_s3[i]   <= PW'(f_s2[i]) + PW'(s_s2[i])
				+ PW'($signed({comp16(origin_q, i), 25'b0}));
			mag_s4[i] <= p_s3[i][PW-1] ? MW'(-p_s3[i]) : MW'(p_s3[i]);
			neg_s4[i] <= p_s3[i][PW-1];
			mag_s5[i] <= mag_s4[i];
			if (h_s5 >= HW'(29)) begin
				nm_s6[i] <= 30'(mag_s5[i] >> (h_s5 - HW'(29)));
			end else begin
				nm_s6[i] <= 30'(mag_s5[i] << (HW'(29) - h_s5));
			end
			sq_s7[i]  <= 60'(nm_s6[i]) * 60'(nm_s6[i]);
		end
		h_s5    <= h_c;
		zero_s5 <= (orv == '0);
		neg_s5  <= neg_s4;
		neg_s6  <= neg_s5;
		zero_s6 <= zero_s5;
		neg_s7  <= neg_s6;
		zero_s7 <= zero_s6;
		nm_s7   <= nm_s6;
		l2_s8   <= SQ_N_W'(sq_s7[0]) + SQ_N_W'(sq_s7[1]) + SQ_N_W'(sq_s7[2]);
		neg_s8  <= neg_s7;
		zero_s8 <= zero_s7;
		nm_s8   <= nm_s7;
	end

	// square root chain
	logic [SQ_REM_W-1:0]  sr_rem  [SQ_ROOT_W+1];
	logic [SQ_ROOT_W-1:0] sr_root [SQ_ROOT_W+1];
	logic [SQ_N_W-1:0]    sr_n    [SQ_ROOT_W+1];
	sq_tag_t              sr_tag  [SQ_ROOT_W+1];
	logic [SQ_ROOT_W:0]   sr_v;

	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;
	assign sr_n[0]    = l2_s8;
	assign sr_tag[0]  = '{zero: zero_s8, neg: neg_s8, nm: nm_s8};
	assign sr_v[0]    = v_s8;

	for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_sqrt
		psv_sqrt_cell u_cell (
			.clk    (clk),
			.rem_i  (sr_rem[k]),
			.root_i (sr_root[k]),
			.n_i    (sr_n[k]),
			.rem_o  (sr_rem[k+1]),
			.root_o (sr_root[k+1]),
			.n_o    (sr_n[k+1])
		);
		always_ff @(posedge clk) begin
			sr_tag[k+1] <= sr_tag[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[k+1] <= 1'b0;
			end else begin
				sr_v[k+1] <= sr_v[k];
			end
		end
	end

	// unit direction chain
	logic [D1_DW-1:0] d1_rem [3][D1_QW+1];
	logic [D1_QW-1:0] d1_low [3][D1_QW+1];
	logic [D1_DW-1:0] d1_div [3][D1_QW+1];
	d_tag_t           d1_tag [D1_QW+1];
	logic [D1_QW:0]   d1_v;

	assign d1_tag[0] = '{zero: sr_tag[SQ_ROOT_W].zero, neg: sr_tag[SQ_ROOT_W].neg};
	assign d1_v[0]   = sr_v[SQ_ROOT_W];

	for (genvar i = 0; i < 3; i++) begin : g_d1_lane
		assign d1_rem[i][0] = D1_DW'(sr_tag[SQ_ROOT_W].nm[i]);
		assign d1_low[i][0] = sr_root[SQ_ROOT_W];
		assign d1_div[i][0] = {sr_root[SQ_ROOT_W], 1'b0};
		for (genvar k = 0; k < D1_QW; k++) begin : g_step
			psv_div_cell #(.DW(D1_DW), .QW(D1_QW)) u_cell (
				.clk   (clk),
				.rem_i (d1_rem[i][k]),
				.low_i (d1_low[i][k]),
				.div_i (d1_div[i][k]),
				.rem_o (d1_rem[i][k+1]),
				.low_o (d1_low[i][k+1]),
				.div_o (d1_div[i][k+1])
			);
		end
	end

	for (genvar k = 0; k < D1_QW; k++) begin : g_d1_side
		always_ff @(posedge clk) begin
			d1_tag[k+1] <= d1_tag[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v[k+1] <= 1'b0;
			end else begin
				d1_v[k+1] <= d1_v[k];
			end
		end
	end

	// beam difference
	logic signed [32:0] e_se [3];
	logic               zero_se, zero_sf;
	logic [N2_W-1:0]    n2_sf [3];
	logic [2:0]         en_sf;
	logic               v_se, v_sf;
	logic [15:0]        wl;
	logic signed [32:0] u_c [3];

	assign wl = (wave_len_q == '0) ? 16'd1 : wave_len_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c[i] = d1_tag[D1_QW].neg[i] ? -$signed(33'(d1_low[i][D1_QW]))
				: $signed(33'(d1_low[i][D1_QW]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_se[i]  <= u_c[i] - 33'($signed({comp16(beam_dir_q, i), 16'b0}));
			en_sf[i] <= e_se[i][32];
			n2_sf[i] <= {(e_se[i][32] ? 32'(-e_se[i]) : 32'(e_se[i])), 3'b000} + N2_W'(wl);
		end
		zero_se <= d1_tag[D1_QW].zero;
		zero_sf <= zero_se;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_se <= 1'b0;
			v_sf <= 1'b0;
		end else begin
			v_se <= d1_v[D1_QW];
			v_sf <= v_se;
		end
	end

	// wavelength division chain
	logic [D2_DW-1:0] d2_rem [3][D2_QW+1];
	logic [D2_QW-1:0] d2_low [3][D2_QW+1];
	logic [D2_DW-1:0] d2_div [3][D2_QW+1];
	d_tag_t           d2_tag [D2_QW+1];
	logic [D2_QW:0]   d2_v;

	assign d2_tag[0] = '{zero: zero_sf, neg: en_sf};
	assign d2_v[0]   = v_sf;

	for (genvar i = 0; i < 3; i++) begin : g_d2_lane
		assign d2_rem[i][0] = D2_DW'(n2_sf[i][N2_W-1]);
		assign d2_low[i][0] = n2_sf[i][D2_QW-1:0];
		assign d2_div[i][0] = {wl, 1'b0};
		for (genvar k = 0; k < D2_QW; k++) begin : g_step
			psv_div_cell #(.DW(D2_DW), .QW(D2_QW)) u_cell (
				.clk   (clk),
				.rem_i (d2_rem[i][k]),
				.low_i (d2_low[i][k]),
				.div_i (d2_div[i][k]),
				.rem_o (d2_rem[i][k+1]),
				.low_o (d2_low[i][k+1]),
				.div_o (d2_div[i][k+1])
			);
		end
	end

	for (genvar k = 0; k < D2_QW; k++) begin : g_d2_side
		always_ff @(posedge clk) begin
			d2_tag[k+1] <= d2_tag[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v[k+1] <= 1'b0;
			end else begin
				d2_v[k+1] <= d2_v[k];
			end
		end
	end

	// saturation and output word
	logic [OUT_BITS-1:0] res_c [3];
	logic [D2_QW-1:0]    q_c;
	logic [OUT_BITS-1:0] s_q [3];
	logic                zero_q;
	logic                done_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_c = d2_low[i][D2_QW];
			if (d2_tag[D2_QW].zero) begin
				res_c[i] = '0;
			end else if (d2_tag[D2_QW].neg[i]) begin
				res_c[i] = -OUT_BITS'((q_c > NMAX) ? NMAX : q_c);
			end else begin
				res_c[i] = OUT_BITS'((q_c > PMAX) ? PMAX : q_c);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_q[i] <= res_c[i];
		end
		zero_q <= d2_tag[D2_QW].zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= d2_v[D2_QW];
		end
	end

	assign done          = done_q;
	assign s_x           = $signed(s_q[0]);
	assign s_y           = $signed(s_q[1]);
	assign s_z           = $signed(s_q[2]);
	assign zero_distance = zero_q;

endmodule

/* tb/sv/psv_checker.sv */
// ----------------------------------------------------------------------------
// psv_checker
// watches the pixel, configuration and result channels of the scattering
// vector block, predicts each result from its own copy of the geometry and
// compares every field of each result word against the oldest prediction
// ----------------------------------------------------------------------------
module psv_checker import psv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [11:0]        pixel_row,
	input  logic [11:0]        pixel_col,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               done,
	input  logic signed [23:0] s_x,
	input  logic signed [23:0] s_y,
	input  logic signed [23:0] s_z,
	input  logic               zero_distance,
	output int                 mismatches,
	output int                 in_flight,
	output int                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [23:0] sx;
		logic signed [23:0] sy;
		logic signed [23:0] sz;
		logic               zd;
	} scatter_t;

	logic [15:0] g_pixel;
	logic [47:0] g_fast;
	logic [47:0] g_slow;
	logic [47:0] g_origin;
	logic [47:0] g_beam;
	logic [15:0] g_wave;
	scatter_t    scatter_q[$];

	function automatic longint lane(input logic [47:0] v, input int i);
		return longint'($signed(v[16*i +: 16]));
	endfunction

	function automatic scatter_t scatter_of(input logic [11:0] row, input logic [11:0] col);
		longint          p;
		longint          u;
		longint          e;
		longint unsigned mag[3];
		bit              neg[3];
		bit              en;
		longint unsigned m;
		longint unsigned l2;
		longint unsigned rad;
		longint unsigned root;
		longint unsigned bitv;
		longint unsigned um;
		longint unsigned em;
		longint unsigned q;
		longint unsigned wl;
		logic [23:0]     sv[3];
		scatter_t        r;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			p = longint'(col) * longint'(g_pixel) * lane(g_fast, i)
				+ longint'(row) * longint'(g_pixel) * lane(g_slow, i)
				+ lane(g_origin, i) * (64'sd1 <<< 25);
			neg[i] = p < 0;
			mag[i] = neg[i] ? longint'(-p) : p;
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			r = '0;
			r.zd = 1'b1;
			return r;
		end
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
		end
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
		end
		l2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
		rad = l2;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rad) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rad >= root + bitv) begin
				rad = rad - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		wl = (g_wave == 0) ? 64'd1 : longint'(g_wave);
		for (int i = 0; i < 3; i++) begin
			um = (2 * (mag[i] << 30) + root) / (2 * root);
			u = neg[i] ? -longint'(um) : longint'(um);
			e = u - lane(g_beam, i) * (64'sd1 <<< 16);
			en = e < 0;
			em = en ? longint'(-e) : e;
			q = (2 * (em * 4) + wl) / (2 * wl);
			if (en) begin
				if (q > (64'd1 << 23)) q = 64'd1 << 23;
				sv[i] = 24'(-q);
			end else begin
				if (q > (64'd1 << 23) - 1) q = (64'd1 << 23) - 1;
				sv[i] = 24'(q);
			end
		end
		r.sx = sv[0];
		r.sy = sv[1];
		r.sz = sv[2];
		r.zd = 1'b0;
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		checked = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		scatter_t w;
		if (!arst_n) begin
			g_pixel  <= '0;
			g_fast   <= '0;
			g_slow   <= '0;
			g_origin <= '0;
			g_beam   <= '0;
			g_wave   <= 16'd4096;
			scatter_q.delete();
			in_flight <= 0;
		end else begin
			if (done) begin
				if (scatter_q.size() == 0) begin
					report("result word with nothing pending", 1, 0);
				end else begin
					w = scatter_q.pop_front();
					if (s_x !== w.sx) report("s_x", s_x, w.sx);
					if (s_y !== w.sy) report("s_y", s_y, w.sy);
					if (s_z !== w.sz) report("s_z", s_z, w.sz);
					if (zero_distance !== w.zd)
						report("zero_distance", zero_distance, w.zd);
					checked++;
				end
			end
			if (start && !busy)
				scatter_q.push_back(scatter_of(pixel_row, pixel_col));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PIXEL_SIZE: g_pixel  <= cfg_data[15:0];
					REG_FAST_AXIS:  g_fast   <= cfg_data;
					REG_SLOW_AXIS:  g_slow   <= cfg_data;
					REG_ORIGIN:     g_origin <= cfg_data;
					REG_BEAM_DIR:   g_beam   <= cfg_data;
					REG_WAVE_LEN:   g_wave   <= cfg_data[15:0];
					default: ;
				endcase
			end
			in_flight <= scatter_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// pixel stimulus and verdict for the scattering vector block: runs a series
// of detector geometries, from reset defaults through realistic to extreme,
// with directed corner pixels and random pixels under random idle bursts
// ----------------------------------------------------------------------------
module tb import psv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;
	localparam int         LATENCY     = 108;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         PHASES      = 9;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [11:0]        pixel_row = '0;
	logic [11:0]        pixel_col = '0;
	logic               cfg_valid = 1'b0;
	logic [2:0]         cfg_index = REG_PIXEL_SIZE;
	logic [47:0]        cfg_data = '0;
	logic               busy;
	logic               cfg_ready;
	logic               done;
	logic signed [23:0] s_x;
	logic signed [23:0] s_y;
	logic signed [23:0] s_z;
	logic               zero_distance;
	int                 mismatches;
	int                 in_flight;
	int                 checked;
	int                 cycles = 0;
	int                 sent = 0;
	int                 cfg_writes = 0;
	bit                 idling = 1'b1;

	always #2 clk = ~clk;

	pixel_scattering_vector dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_row(pixel_row), .pixel_col(pixel_col),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .s_x(s_x), .s_y(s_y), .s_z(s_z),
		.zero_distance(zero_distance)
	);

	psv_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_row(pixel_row), .pixel_col(pixel_col),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .s_x(s_x), .s_y(s_y), .s_z(s_z),
		.zero_distance(zero_distance),
		.mismatches(mismatches), .in_flight(in_flight), .checked(checked)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** pixel_scattering_vector: FAILED **");
			$finish;
		end
	end

	function automatic logic [47:0] vec3(input int x, input int y, input int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// cfg_valid stays high across back-to-back words
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_writes++;
	endtask

	task automatic set_geometry(input logic [15:0] ps, input logic [47:0] fa,
		input logic [47:0] sa, input logic [47:0] org, input logic [47:0] bd,
		input logic [15:0] wl);
		// junk above the 16-bit registers must be ignored
		write_reg(REG_PIXEL_SIZE, {32'($urandom), ps});
		write_reg(REG_FAST_AXIS, fa);
		if ($urandom_range(0, 1)) write_reg(REG_SPARE_6, rand48());
		write_reg(REG_SLOW_AXIS, sa);
		write_reg(REG_ORIGIN, org);
		if ($urandom_range(0, 1)) write_reg(REG_SPARE_7, rand48());
		write_reg(REG_BEAM_DIR, bd);
		write_reg(REG_WAVE_LEN, {32'($urandom), wl});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [11:0] row, input logic [11:0] col);
		int gap;
		if (idling && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		pixel_row <= row;
		pixel_col <= col;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
	endtask

	function automatic logic [11:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 12'd0;
			1: return 12'd4095;
			2: return 12'($urandom_range(0, 15));
			default: return 12'($urandom);
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == PHASES - 1) idling = 1'b0;
			case (ph)
				0: ; // reset geometry: every pixel lands at zero
				1: set_geometry(16'h0B00, vec3(16384, 0, 0), vec3(0, -16384, 0),
					vec3(-2560, 2560, 6400), vec3(0, 0, 16384), 16'h1000);
				2: set_geometry(16'hFFFF, vec3(-32768, -32768, -32768),
					vec3(32767, 32767, 32767), vec3(0, 0, 0),
					vec3(-32768, 32767, -32768), 16'd1);
				3: set_geometry(16'hFFFF, vec3(32767, -32768, 0),
					vec3(0, 32767, -32768), vec3(32767, -32768, 32767),
					vec3(32767, 32767, 32767), 16'hFFFF);
				4: set_geometry(16'd1, vec3(1, 0, 0), vec3(0, 1, 0),
					vec3(0, 0, 0), vec3(0, 0, 0), 16'd0);
				5: set_geometry(16'h0200, vec3(11585, 11585, 0), vec3(0, 0, -16384),
					vec3(-32768, 0, 3200), vec3(16384, 0, 0), 16'h0800);
				default: set_geometry(16'($urandom), rand48(), rand48(), rand48(),
					rand48(), 16'($urandom_range(0, 65535)));
			endcase
			// corners, the origin pixel, two checkerboard pixels and pixel (1,1)
			send_pixel(12'd0, 12'd0);
			send_pixel(12'd4095, 12'd4095);
			send_pixel(12'd0, 12'd4095);
			send_pixel(12'd4095, 12'd0);
			send_pixel(12'hAAA, 12'h555);
			send_pixel(12'h555, 12'hAAA);
			send_pixel(12'd1, 12'd1);
			repeat (ph == 0 ? 10 : 85) send_pixel(rand_coord(), rand_coord());
			drain();
		end

		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d pixels over %0d geometries, %0d register words, %0d results checked",
			sent, PHASES, cfg_writes, checked);
		if (mismatches == 0 && in_flight == 0) begin
			$display("** pixel_scattering_vector: PASSED **");
		end else begin
			$display("** pixel_scattering_vector: FAILED **");
		end
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/psv_pkg.sv
hw/rtl/psv_sqrt_cell.sv
hw/rtl/psv_div_cell.sv
hw/rtl/pixel_scattering_vector.sv
tb/sv/psv_checker.sv
tb/sv/tb.sv
